// File: rtl/core/mvrm_pkg.sv
// Shared types and constants of the multi-voice resampling mixer.
// Used by every module below rtl/core except mvrm_ram; depends on nothing.
package mvrm_pkg;

  localparam int VOICES       = 8;
  localparam int SAMPLE_WORDS = 65536;
  localparam int FRAC_BITS    = 16;

  localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int ADDR_W  = $clog2(SAMPLE_WORDS);
  localparam int LEN_W   = 17;
  localparam int GAIN_W  = 17;
  localparam int STEP_W  = 21;
  localparam int POS_W   = LEN_W + FRAC_BITS;
  localparam int CHK_W   = 26;
  localparam int MA_W    = 18;
  localparam int MB_W    = (FRAC_BITS + 1 > 18) ? FRAC_BITS + 1 : 18;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int NUM_W   = PROD_W + 1;
  localparam int ACC_W   = 18 + $clog2(VOICES + 1);

  localparam logic [CHK_W-1:0]  SAMPLE_WORDS_C = CHK_W'(SAMPLE_WORDS);
  localparam logic [GAIN_W-1:0] UNITY_GAIN     = 17'd65536;

  // command codes
  localparam logic [2:0] CMD_MIX      = 3'd0;
  localparam logic [2:0] CMD_WRITE    = 3'd1;
  localparam logic [2:0] CMD_START    = 3'd2;
  localparam logic [2:0] CMD_STOP     = 3'd3;
  localparam logic [2:0] CMD_STOP_ALL = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_VOICE = 2'd1;
  localparam logic [1:0] ST_BAD_CLIP = 2'd2;

  // register indexes
  localparam logic CFG_OUT_CHANNELS  = 1'b0;
  localparam logic CFG_MASTER_VOLUME = 1'b1;

  // sample fetch phases: four reads, one trailing capture
  localparam logic [2:0] RD_LAST = 3'd4;

  typedef struct packed {
    logic [2:0]         command;
    logic [15:0]        sample_address;
    logic signed [15:0] sample_value;
    logic [16:0]        clip_frames;
    logic               clip_stereo;
    logic               loop_enable;
    logic [16:0]        voice_volume;
    logic [20:0]        step_ratio;
    logic [2:0]         voice_id;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
    logic [2:0]         assigned_voice;
    logic [1:0]         status;
  } out_t;

  typedef enum logic [3:0] {
    DP_NONE, DP_EXEC, DP_CHECK, DP_MOD, DP_READ, DP_MG, DP_MDL, DP_MDR,
    DP_MSL, DP_MSR, DP_ACC, DP_FIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e            op;
    logic [VIDX_W-1:0] voice;
    logic [2:0]        phase;
  } dp_cmd_t;

  typedef struct packed {
    logic active;
    logic past_end;
    logic loop;
  } dp_status_t;

endpackage

// File: rtl/core/mvrm_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module mvrm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/mvrm_ctrl.sv
// Mixer controller: request handshake, per-voice sequencing, result valid.
// Depends on mvrm_pkg.
module mvrm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [2:0]           in_command_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  mvrm_pkg::dp_status_t dp_st_i,
  output mvrm_pkg::dp_cmd_t    dp_cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CHECK = 11'b00000000010,
    S_MOD   = 11'b00000000100,
    S_READ  = 11'b00000001000,
    S_MG    = 11'b00000010000,
    S_MDL   = 11'b00000100000,
    S_MDR   = 11'b00001000000,
    S_MSL   = 11'b00010000000,
    S_MSR   = 11'b00100000000,
    S_ACC   = 11'b01000000000,
    S_FIN   = 11'b10000000000
  } state_e;

  state_e                      state_q, state_d;
  logic [mvrm_pkg::VIDX_W-1:0] voice_q, voice_d;
  logic [2:0]                  phase_q, phase_d;
  logic                        out_valid_q, out_valid_d;
  logic                        accept, last_voice;

  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign last_voice  = (voice_q == mvrm_pkg::VIDX_W'(mvrm_pkg::VOICES - 1));

  always_comb begin
    state_d        = state_q;
    voice_d        = voice_q;
    phase_d        = phase_q;
    out_valid_d    = out_valid_q && out_stall_i;
    dp_cmd_o.op    = mvrm_pkg::DP_NONE;
    dp_cmd_o.voice = voice_q;
    dp_cmd_o.phase = phase_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          dp_cmd_o.op = mvrm_pkg::DP_EXEC;
          if (in_command_i == mvrm_pkg::CMD_MIX) begin
            state_d = S_CHECK;
            voice_d = '0;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      S_CHECK: begin
        dp_cmd_o.op = mvrm_pkg::DP_CHECK;
        if (dp_st_i.active && !dp_st_i.past_end) begin
          state_d = S_READ;
          phase_d = '0;
        end else if (dp_st_i.active && dp_st_i.loop) begin
          state_d = S_MOD;
        end else if (last_voice) begin
          state_d = S_FIN;
        end else begin
          voice_d = voice_q + 1'b1;
        end
      end
      S_MOD: begin
        // subtract the clip span until the position falls inside
        if (dp_st_i.past_end) begin
          dp_cmd_o.op = mvrm_pkg::DP_MOD;
        end else begin
          state_d = S_READ;
          phase_d = '0;
        end
      end
      S_READ: begin
        dp_cmd_o.op = mvrm_pkg::DP_READ;
        if (phase_q == mvrm_pkg::RD_LAST) begin
          state_d = S_MG;
        end else begin
          phase_d = phase_q + 1'b1;
        end
      end
      S_MG: begin
        dp_cmd_o.op = mvrm_pkg::DP_MG;
        state_d     = S_MDL;
      end
      S_MDL: begin
        dp_cmd_o.op = mvrm_pkg::DP_MDL;
        state_d     = S_MDR;
      end
      S_MDR: begin
        dp_cmd_o.op = mvrm_pkg::DP_MDR;
        state_d     = S_MSL;
      end
      S_MSL: begin
        dp_cmd_o.op = mvrm_pkg::DP_MSL;
        state_d     = S_MSR;
      end
      S_MSR: begin
        dp_cmd_o.op = mvrm_pkg::DP_MSR;
        state_d     = S_ACC;
      end
      S_ACC: begin
        dp_cmd_o.op = mvrm_pkg::DP_ACC;
        if (last_voice) begin
          state_d = S_FIN;
        end else begin
          voice_d = voice_q + 1'b1;
          state_d = S_CHECK;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          dp_cmd_o.op = mvrm_pkg::DP_FIN;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      voice_q     <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      voice_q     <= voice_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/core/mvrm_dp.sv
// Mixer datapath: voice table, sample memory, shared multiplier, accumulators,
// result register. Depends on mvrm_pkg and mvrm_ram.
module mvrm_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mvrm_pkg::in_t        in_data_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [16:0]          cfg_data_i,
  input  mvrm_pkg::dp_cmd_t    dp_cmd_i,
  output mvrm_pkg::dp_status_t dp_st_o,
  output mvrm_pkg::out_t       out_data_o
);

  localparam int F = mvrm_pkg::FRAC_BITS;

  logic [mvrm_pkg::VOICES-1:0] active_q, loop_q, stereo_q;
  logic [mvrm_pkg::GAIN_W-1:0] gain_q  [mvrm_pkg::VOICES];
  logic [mvrm_pkg::POS_W-1:0]  pos_q   [mvrm_pkg::VOICES];
  logic [mvrm_pkg::STEP_W-1:0] step_q  [mvrm_pkg::VOICES];
  logic [15:0]                 start_q [mvrm_pkg::VOICES];
  logic [mvrm_pkg::LEN_W-1:0]  len_q   [mvrm_pkg::VOICES];

  logic [1:0]                  chan_q;
  logic [mvrm_pkg::GAIN_W-1:0] master_q;

  logic signed [15:0]          samp_q [4];
  logic signed [mvrm_pkg::PROD_W-1:0] prod_q, prod_d;
  logic [mvrm_pkg::GAIN_W-1:0] g_q;
  logic signed [15:0]          lerp_l_q, lerp_r_q;
  logic signed [mvrm_pkg::ACC_W-1:0] acc_l_q, acc_r_q;
  mvrm_pkg::out_t              out_q;
  mvrm_pkg::out_t              exec_res;

  logic [mvrm_pkg::VIDX_W-1:0] cur;
  logic [mvrm_pkg::LEN_W-1:0]  len_cur, i0, i1, sel_i;
  logic [mvrm_pkg::LEN_W:0]    i0p1;
  logic [mvrm_pkg::POS_W-1:0]  pos_cur, end_w;
  logic                        past_end, right;
  logic [17:0]                 off;
  logic [mvrm_pkg::CHK_W-1:0]  raddr_wide;
  logic [15:0]                 rdata;
  logic                        ram_we;

  logic signed [mvrm_pkg::MA_W-1:0] mul_a;
  logic signed [mvrm_pkg::MB_W-1:0] mul_b;
  logic signed [16:0]          diff_l, diff_r;
  logic signed [15:0]          s0_sel;
  logic signed [mvrm_pkg::NUM_W-1:0] num, num_adj;
  logic signed [15:0]          lerp_val;
  logic signed [mvrm_pkg::PROD_W-1:0] sc_adj;
  logic signed [mvrm_pkg::ACC_W-1:0]  contrib;

  logic [17:0]                 words;
  logic                        bad_clip, free_found;
  logic [mvrm_pkg::VIDX_W-1:0] free_idx;
  logic [mvrm_pkg::GAIN_W-1:0] vol_sat, cfg_sat;

  logic signed [15:0]          cl, cr, mono, fin_l, fin_r;
  logic signed [16:0]          msum;

  function automatic logic signed [15:0] clamp16(
    input logic signed [mvrm_pkg::ACC_W-1:0] v
  );
    logic signed [15:0] r;
    if (v < -mvrm_pkg::ACC_W'(32768)) begin
      r = -16'sd32768;
    end else if (v > mvrm_pkg::ACC_W'(32767)) begin
      r = 16'sd32767;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  assign cur      = dp_cmd_i.voice;
  assign len_cur  = len_q[cur];
  assign pos_cur  = pos_q[cur];
  assign end_w    = {len_cur, {F{1'b0}}};
  assign past_end = (pos_cur >= end_w);

  assign dp_st_o.active   = active_q[cur];
  assign dp_st_o.past_end = past_end;
  assign dp_st_o.loop     = loop_q[cur];

  // frame indexes of the two interpolation points
  assign i0    = pos_cur[mvrm_pkg::POS_W-1:F];
  assign i0p1  = {1'b0, i0} + 1'b1;
  assign i1    = (i0p1 < {1'b0, len_cur}) ? i0p1[mvrm_pkg::LEN_W-1:0] : len_cur - 1'b1;
  assign sel_i = dp_cmd_i.phase[0] ? i1 : i0;
  assign right = dp_cmd_i.phase[1] & stereo_q[cur];
  assign off   = stereo_q[cur] ? {sel_i, right} : {1'b0, sel_i};
  assign raddr_wide = mvrm_pkg::CHK_W'(start_q[cur]) + mvrm_pkg::CHK_W'(off);

  assign ram_we = (dp_cmd_i.op == mvrm_pkg::DP_EXEC) &&
                  (in_data_i.command == mvrm_pkg::CMD_WRITE) &&
                  (mvrm_pkg::CHK_W'(in_data_i.sample_address) < mvrm_pkg::SAMPLE_WORDS_C);

  mvrm_ram #(
    .WIDTH(16),
    .DEPTH(mvrm_pkg::SAMPLE_WORDS)
  ) u_samples (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(mvrm_pkg::ADDR_W'(in_data_i.sample_address)),
    .wdata_i(in_data_i.sample_value),
    .raddr_i(raddr_wide[mvrm_pkg::ADDR_W-1:0]),
    .rdata_o(rdata)
  );

  // shared multiplier
  assign diff_l = {samp_q[1][15], samp_q[1]} - {samp_q[0][15], samp_q[0]};
  assign diff_r = {samp_q[3][15], samp_q[3]} - {samp_q[2][15], samp_q[2]};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (dp_cmd_i.op)
      mvrm_pkg::DP_MG: begin
        mul_a = mvrm_pkg::MA_W'(gain_q[cur]);
        mul_b = mvrm_pkg::MB_W'(master_q);
      end
      mvrm_pkg::DP_MDL: begin
        mul_a = mvrm_pkg::MA_W'(diff_l);
        mul_b = mvrm_pkg::MB_W'(pos_cur[F-1:0]);
      end
      mvrm_pkg::DP_MDR: begin
        mul_a = mvrm_pkg::MA_W'(diff_r);
        mul_b = mvrm_pkg::MB_W'(pos_cur[F-1:0]);
      end
      mvrm_pkg::DP_MSL: begin
        mul_a = mvrm_pkg::MA_W'(lerp_l_q);
        mul_b = mvrm_pkg::MB_W'(g_q);
      end
      mvrm_pkg::DP_MSR: begin
        mul_a = mvrm_pkg::MA_W'(lerp_r_q);
        mul_b = mvrm_pkg::MB_W'(g_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // interpolation: s0 * 2^F + (s1 - s0) * t, truncated toward zero
  assign s0_sel   = (dp_cmd_i.op == mvrm_pkg::DP_MDR) ? samp_q[0] : samp_q[2];
  assign num      = (mvrm_pkg::NUM_W'(s0_sel) <<< F) + mvrm_pkg::NUM_W'(prod_q);
  assign num_adj  = num + (num[mvrm_pkg::NUM_W-1] ? mvrm_pkg::NUM_W'((1 << F) - 1)
                                                  : mvrm_pkg::NUM_W'(0));
  assign lerp_val = 16'(num_adj >>> F);

  // gain scaling: divide by 65536 toward zero
  assign sc_adj  = prod_q + (prod_q[mvrm_pkg::PROD_W-1] ? mvrm_pkg::PROD_W'(65535)
                                                        : mvrm_pkg::PROD_W'(0));
  assign contrib = mvrm_pkg::ACC_W'(17'(sc_adj >>> 16));

  // start checks and lowest free slot
  assign words    = in_data_i.clip_stereo ? {in_data_i.clip_frames, 1'b0}
                                          : {1'b0, in_data_i.clip_frames};
  assign bad_clip = (in_data_i.clip_frames == '0) ||
                    (mvrm_pkg::CHK_W'(in_data_i.sample_address) + mvrm_pkg::CHK_W'(words)
                     > mvrm_pkg::SAMPLE_WORDS_C);
  assign vol_sat  = (in_data_i.voice_volume > mvrm_pkg::UNITY_GAIN) ? mvrm_pkg::UNITY_GAIN
                                                                    : in_data_i.voice_volume;
  assign cfg_sat  = (cfg_data_i > mvrm_pkg::UNITY_GAIN) ? mvrm_pkg::UNITY_GAIN : cfg_data_i;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int v = mvrm_pkg::VOICES - 1; v >= 0; v--) begin
      if (!active_q[v]) begin
        free_found = 1'b1;
        free_idx   = mvrm_pkg::VIDX_W'(v);
      end
    end
  end

  // result of a request that finishes at once
  always_comb begin
    exec_res = '0;
    if (in_data_i.command == mvrm_pkg::CMD_START) begin
      if (bad_clip) begin
        exec_res.status = mvrm_pkg::ST_BAD_CLIP;
      end else if (!free_found) begin
        exec_res.status = mvrm_pkg::ST_NO_VOICE;
      end else begin
        exec_res.assigned_voice = 3'(free_idx);
      end
    end
  end

  // final saturation and optional mono downmix
  assign cl    = clamp16(acc_l_q);
  assign cr    = clamp16(acc_r_q);
  assign msum  = {cl[15], cl} + {cr[15], cr};
  assign mono  = 16'((msum + {16'd0, msum[16]}) >>> 1);
  assign fin_l = chan_q[1] ? cl : mono;
  assign fin_r = chan_q[1] ? cr : mono;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      loop_q   <= '0;
      chan_q   <= 2'd2;
      master_q <= mvrm_pkg::UNITY_GAIN;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          mvrm_pkg::CFG_OUT_CHANNELS:  chan_q   <= cfg_data_i[1:0];
          mvrm_pkg::CFG_MASTER_VOLUME: master_q <= cfg_sat;
          default: ;
        endcase
      end
      if (dp_cmd_i.op == mvrm_pkg::DP_EXEC) begin
        unique case (in_data_i.command)
          mvrm_pkg::CMD_START: begin
            if (!bad_clip && free_found) begin
              active_q[free_idx] <= 1'b1;
              loop_q[free_idx]   <= in_data_i.loop_enable;
            end
          end
          mvrm_pkg::CMD_STOP: begin
            if (int'(in_data_i.voice_id) < mvrm_pkg::VOICES) begin
              active_q[mvrm_pkg::VIDX_W'(in_data_i.voice_id)] <= 1'b0;
            end
          end
          mvrm_pkg::CMD_STOP_ALL: active_q <= '0;
          default: ;
        endcase
      end
      // drop a voice that ran off the end of a one-shot clip
      if (dp_cmd_i.op == mvrm_pkg::DP_CHECK && active_q[cur] && past_end && !loop_q[cur]) begin
        active_q[cur] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (dp_cmd_i.op)
      mvrm_pkg::DP_EXEC: begin
        out_q <= exec_res;
        unique case (in_data_i.command)
          mvrm_pkg::CMD_MIX: begin
            acc_l_q <= '0;
            acc_r_q <= '0;
          end
          mvrm_pkg::CMD_START: begin
            if (!bad_clip && free_found) begin
              gain_q[free_idx]   <= vol_sat;
              pos_q[free_idx]    <= '0;
              step_q[free_idx]   <= in_data_i.step_ratio;
              start_q[free_idx]  <= in_data_i.sample_address;
              len_q[free_idx]    <= in_data_i.clip_frames;
              stereo_q[free_idx] <= in_data_i.clip_stereo;
            end
          end
          default: ;
        endcase
      end
      mvrm_pkg::DP_MOD: pos_q[cur] <= pos_cur - end_w;
      mvrm_pkg::DP_READ: begin
        if (dp_cmd_i.phase != '0) begin
          samp_q[2'(dp_cmd_i.phase - 1'b1)] <= rdata;
        end
      end
      mvrm_pkg::DP_MDL: g_q <= prod_q[32:16];
      mvrm_pkg::DP_MDR: lerp_l_q <= lerp_val;
      mvrm_pkg::DP_MSL: lerp_r_q <= lerp_val;
      mvrm_pkg::DP_MSR: acc_l_q <= acc_l_q + contrib;
      mvrm_pkg::DP_ACC: begin
        acc_r_q    <= acc_r_q + contrib;
        pos_q[cur] <= pos_cur + mvrm_pkg::POS_W'(step_q[cur]);
      end
      mvrm_pkg::DP_FIN: out_q <= {fin_l, fin_r, 3'd0, mvrm_pkg::ST_OK};
      default: ;
    endcase
  end

  assign out_data_o = out_q;

endmodule

// File: rtl/core/multi_voice_resampling_mixer_top.sv
// Multi-voice resampling mixer, top level: controller plus datapath.
// Depends on mvrm_pkg, mvrm_ctrl, mvrm_dp (and through it mvrm_ram).
//
// One request is taken at a time. Sample writes, starts, stops and stop-all
// finish directly, their result registered on acceptance. A mix request walks
// the voice slots in order: an idle slot takes only a check, a playing slot one
// check, four reads from the single read port of the sample memory, then six
// steps through the one shared multiplier, plus the steps that subtract the clip
// span when a looping voice wraps; a final step saturates and loads the result.
// A new request is taken only while the result register is empty or being read,
// so a stalled result holds the input.
module multi_voice_resampling_mixer_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mvrm_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mvrm_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic           cfg_index_i,
  input  logic [16:0]    cfg_data_i
);

  mvrm_pkg::dp_cmd_t    dp_cmd;
  mvrm_pkg::dp_status_t dp_st;

  mvrm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_command_i(in_data_i.command),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dp_st_i     (dp_st),
    .dp_cmd_o    (dp_cmd)
  );

  mvrm_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .dp_cmd_i   (dp_cmd),
    .dp_st_o    (dp_st),
    .out_data_o (out_data_o)
  );

endmodule
